FILE: hw/rtl/iibs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integral image box sum package
// Shared sizes, codes and the queue word passed from the front to the back.
// ----------------------------------------------------------------------------
package iibs_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;

   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int DIM_W    = 10;
   localparam int COORD_W  = 9;
   localparam int QEND_W   = DIM_W + 1;
   localparam int ADDR_W   = ROW_W + COL_W;
   localparam int CHAN_W   = 8;
   localparam int GRAY_W   = 8;
   localparam int GRAY_SUM_W = 16;
   localparam int RSUM_W   = 17;
   localparam int TOTAL_W  = 26;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 10;

   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_W = QUEUE_PTR_W + 1;

   // Fixed-point gray weights, scaled by 256, with round-to-nearest offset.
   localparam logic [GRAY_SUM_W-1:0] GRAY_WEIGHT_A = GRAY_SUM_W'(54);
   localparam logic [GRAY_SUM_W-1:0] GRAY_WEIGHT_B = GRAY_SUM_W'(184);
   localparam logic [GRAY_SUM_W-1:0] GRAY_WEIGHT_C = GRAY_SUM_W'(18);
   localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND    = GRAY_SUM_W'(128);

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      logic                   en;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   // For a pixel, x1/y1 give its own position and y0 the row above.
   // For a query, x0/y0 give the column and row just outside the box and
   // x1/y1 its last column and row.
   typedef struct packed {
      op_type              op;
      logic [GRAY_W-1:0]   gray;
      logic [RSUM_W-1:0]   row_sum;
      logic                outside;
      logic [COL_W-1:0]    x0;
      logic [ROW_W-1:0]    y0;
      logic [COL_W-1:0]    x1;
      logic [ROW_W-1:0]    y1;
      logic                left_ok;
      logic                top_ok;
   } entry_type;

endpackage
`default_nettype wire

FILE: hw/rtl/iibs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integral image box sum front end
// Takes words, holds the frame registers and position counters, converts
// pixels to gray and checks query boxes before queueing them.
// ----------------------------------------------------------------------------
module iibs_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            op,
   input  wire logic [iibs_pkg::CHAN_W-1:0]     chan_a,
   input  wire logic [iibs_pkg::CHAN_W-1:0]     chan_b,
   input  wire logic [iibs_pkg::CHAN_W-1:0]     chan_c,
   input  wire logic [iibs_pkg::COORD_W-1:0]    query_x,
   input  wire logic [iibs_pkg::COORD_W-1:0]    query_y,
   input  wire logic [iibs_pkg::DIM_W-1:0]      box_width,
   input  wire logic [iibs_pkg::DIM_W-1:0]      box_height,
   input  wire iibs_pkg::csr_write_type         csr,
   output logic                                 push_en,
   output iibs_pkg::entry_type                  push_entry,
   input  wire logic                            queue_full
);

   logic                            item_valid_ff;
   iibs_pkg::op_type                item_op_ff;
   logic [iibs_pkg::CHAN_W-1:0]     chan_a_ff;
   logic [iibs_pkg::CHAN_W-1:0]     chan_b_ff;
   logic [iibs_pkg::CHAN_W-1:0]     chan_c_ff;
   logic [iibs_pkg::COORD_W-1:0]    query_x_ff;
   logic [iibs_pkg::COORD_W-1:0]    query_y_ff;
   logic [iibs_pkg::DIM_W-1:0]      box_width_ff;
   logic [iibs_pkg::DIM_W-1:0]      box_height_ff;

   logic [iibs_pkg::DIM_W-1:0]      width_reg_ff;
   logic [iibs_pkg::DIM_W-1:0]      height_reg_ff;
   logic [iibs_pkg::COL_W-1:0]      col_ff;
   logic [iibs_pkg::ROW_W-1:0]      row_ff;
   logic [iibs_pkg::RSUM_W-1:0]     rsum_ff;

   logic [iibs_pkg::COL_W-1:0]      col_in;
   logic [iibs_pkg::ROW_W-1:0]      row_in;
   logic [iibs_pkg::RSUM_W-1:0]     rsum_in;

   logic                            accept;
   logic [iibs_pkg::DIM_W-1:0]      eff_width;
   logic [iibs_pkg::DIM_W-1:0]      eff_height;
   logic [iibs_pkg::GRAY_SUM_W-1:0] gray_sum;
   logic [iibs_pkg::GRAY_W-1:0]     gray;
   logic                            out_of_frame;
   logic [iibs_pkg::COL_W-1:0]      col_cur;
   logic [iibs_pkg::ROW_W-1:0]      row_cur;
   logic [iibs_pkg::DIM_W-1:0]      col_plus;
   logic [iibs_pkg::DIM_W-1:0]      row_plus;
   logic [iibs_pkg::QEND_W-1:0]     x_end;
   logic [iibs_pkg::QEND_W-1:0]     y_end;
   logic [iibs_pkg::QEND_W-1:0]     x_last;
   logic [iibs_pkg::QEND_W-1:0]     y_last;
   logic                            box_outside;

   assign busy    = item_valid_ff & queue_full;
   assign accept  = start & ~busy;
   assign push_en = item_valid_ff & ~queue_full;

   // A zero register acts as one; a register above the maximum is clamped.
   always_comb begin
      if (width_reg_ff == '0) begin
         eff_width = iibs_pkg::DIM_W'(1);
      end else if (width_reg_ff > iibs_pkg::DIM_W'(iibs_pkg::MAX_WIDTH)) begin
         eff_width = iibs_pkg::DIM_W'(iibs_pkg::MAX_WIDTH);
      end else begin
         eff_width = width_reg_ff;
      end
      if (height_reg_ff == '0) begin
         eff_height = iibs_pkg::DIM_W'(1);
      end else if (height_reg_ff > iibs_pkg::DIM_W'(iibs_pkg::MAX_HEIGHT)) begin
         eff_height = iibs_pkg::DIM_W'(iibs_pkg::MAX_HEIGHT);
      end else begin
         eff_height = height_reg_ff;
      end
   end

   // The weighted sum peaks below 2^16, so the gray value never saturates.
   assign gray_sum = iibs_pkg::GRAY_WEIGHT_A * iibs_pkg::GRAY_SUM_W'(chan_a_ff)
                   + iibs_pkg::GRAY_WEIGHT_B * iibs_pkg::GRAY_SUM_W'(chan_b_ff)
                   + iibs_pkg::GRAY_WEIGHT_C * iibs_pkg::GRAY_SUM_W'(chan_c_ff)
                   + iibs_pkg::GRAY_ROUND;
   assign gray = gray_sum[iibs_pkg::GRAY_SUM_W-1 -: iibs_pkg::GRAY_W];

   // A frame shrunk under the current position starts over at the origin.
   assign out_of_frame = (iibs_pkg::DIM_W'(col_ff) >= eff_width) ||
                         (iibs_pkg::DIM_W'(row_ff) >= eff_height);
   assign col_cur  = out_of_frame ? '0 : col_ff;
   assign row_cur  = out_of_frame ? '0 : row_ff;
   assign col_plus = iibs_pkg::DIM_W'(col_cur) + iibs_pkg::DIM_W'(1);
   assign row_plus = iibs_pkg::DIM_W'(row_cur) + iibs_pkg::DIM_W'(1);

   always_comb begin
      if (out_of_frame || col_cur == '0) begin
         rsum_in = iibs_pkg::RSUM_W'(gray);
      end else begin
         rsum_in = rsum_ff + iibs_pkg::RSUM_W'(gray);
      end
      if (col_plus >= eff_width) begin
         col_in = '0;
         row_in = (row_plus >= eff_height) ? '0 : row_plus[iibs_pkg::ROW_W-1:0];
      end else begin
         col_in = col_plus[iibs_pkg::COL_W-1:0];
         row_in = row_cur;
      end
   end

   assign x_end  = iibs_pkg::QEND_W'(query_x_ff) + iibs_pkg::QEND_W'(box_width_ff);
   assign y_end  = iibs_pkg::QEND_W'(query_y_ff) + iibs_pkg::QEND_W'(box_height_ff);
   assign x_last = x_end - iibs_pkg::QEND_W'(1);
   assign y_last = y_end - iibs_pkg::QEND_W'(1);
   assign box_outside = (box_width_ff == '0) || (box_height_ff == '0) ||
                        (x_end > iibs_pkg::QEND_W'(eff_width)) ||
                        (y_end > iibs_pkg::QEND_W'(eff_height));

   always_comb begin
      push_entry.op = item_op_ff;
      unique case (item_op_ff)
         iibs_pkg::OP_PIXEL: begin
            push_entry.gray    = gray;
            push_entry.row_sum = rsum_in;
            push_entry.outside = 1'b0;
            push_entry.x0      = col_cur;
            push_entry.y0      = row_cur - iibs_pkg::ROW_W'(1);
            push_entry.x1      = col_cur;
            push_entry.y1      = row_cur;
            push_entry.left_ok = col_cur != '0;
            push_entry.top_ok  = row_cur != '0;
         end
         iibs_pkg::OP_QUERY: begin
            push_entry.gray    = '0;
            push_entry.row_sum = '0;
            push_entry.outside = box_outside;
            push_entry.x0      = iibs_pkg::COL_W'(query_x_ff - iibs_pkg::COORD_W'(1));
            push_entry.y0      = iibs_pkg::ROW_W'(query_y_ff - iibs_pkg::COORD_W'(1));
            push_entry.x1      = x_last[iibs_pkg::COL_W-1:0];
            push_entry.y1      = y_last[iibs_pkg::ROW_W-1:0];
            push_entry.left_ok = query_x_ff != '0;
            push_entry.top_ok  = query_y_ff != '0;
         end
         default: begin
            push_entry.gray    = '0;
            push_entry.row_sum = '0;
            push_entry.outside = 1'b0;
            push_entry.x0      = '0;
            push_entry.y0      = '0;
            push_entry.x1      = '0;
            push_entry.y1      = '0;
            push_entry.left_ok = 1'b0;
            push_entry.top_ok  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         width_reg_ff  <= iibs_pkg::DIM_W'(iibs_pkg::MAX_WIDTH);
         height_reg_ff <= iibs_pkg::DIM_W'(iibs_pkg::MAX_HEIGHT);
         col_ff        <= '0;
         row_ff        <= '0;
         rsum_ff       <= '0;
      end else begin
         if (accept) begin
            item_valid_ff <= 1'b1;
         end else if (push_en) begin
            item_valid_ff <= 1'b0;
         end
         if (push_en && item_op_ff == iibs_pkg::OP_PIXEL) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            rsum_ff <= rsum_in;
         end
         // Any register write restarts the frame.
         if (csr.en) begin
            unique case (csr.index)
               iibs_pkg::CSR_IMAGE_WIDTH:  width_reg_ff  <= csr.data;
               iibs_pkg::CSR_IMAGE_HEIGHT: height_reg_ff <= csr.data;
               default: ;
            endcase
            col_ff  <= '0;
            row_ff  <= '0;
            rsum_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_op_ff    <= iibs_pkg::op_type'(op);
         chan_a_ff     <= chan_a;
         chan_b_ff     <= chan_b;
         chan_c_ff     <= chan_c;
         query_x_ff    <= query_x;
         query_y_ff    <= query_y;
         box_width_ff  <= box_width;
         box_height_ff <= box_height;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/iibs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integral image box sum queue
// Short first-in first-out buffer of classified words between front and back.
// ----------------------------------------------------------------------------
module iibs_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_en,
   input  wire iibs_pkg::entry_type  push_entry,
   output logic                      full,
   input  wire logic                 pop_en,
   output iibs_pkg::entry_type       head,
   output logic                      empty
);

   iibs_pkg::entry_type                   entries_ff [iibs_pkg::QUEUE_DEPTH];
   logic [iibs_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff;
   logic [iibs_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff;
   logic [iibs_pkg::QUEUE_COUNT_W-1:0]    count_ff;
   logic [iibs_pkg::QUEUE_COUNT_W-1:0]    count_in;

   assign full  = count_ff == iibs_pkg::QUEUE_COUNT_W'(iibs_pkg::QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = entries_ff[rd_ptr_ff];

   assign count_in = count_ff + iibs_pkg::QUEUE_COUNT_W'(push_en)
                              - iibs_pkg::QUEUE_COUNT_W'(pop_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_en) begin
            wr_ptr_ff <= wr_ptr_ff + iibs_pkg::QUEUE_PTR_W'(1);
         end
         if (pop_en) begin
            rd_ptr_ff <= rd_ptr_ff + iibs_pkg::QUEUE_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push_en && !pop_en) |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop_en |-> !empty)
      else $error("queue read while empty");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff == rd_ptr_ff) |->
         (count_ff == '0 ||
          count_ff == iibs_pkg::QUEUE_COUNT_W'(iibs_pkg::QUEUE_DEPTH)))
      else $error("queue pointers disagree with the fill count");

endmodule
`default_nettype wire

FILE: hw/rtl/iibs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integral image box sum back end
// Owns the single-port frame store: finishes and writes summed-area values
// for pixels and reads the four box corners for queries.
// ----------------------------------------------------------------------------
module iibs_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           queue_empty,
   input  wire iibs_pkg::entry_type            head,
   output logic                                pop_en,
   output logic                                rsp_valid,
   output logic [iibs_pkg::GRAY_W-1:0]         rsp_gray,
   output logic [iibs_pkg::TOTAL_W-1:0]        rsp_running_total,
   output logic [iibs_pkg::TOTAL_W-1:0]        rsp_box_sum,
   output logic                                rsp_outside
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PIX_WR,
      S_READ_B,
      S_READ_C,
      S_READ_D,
      S_Q_DONE
   } state_type;

   state_type                        state_ff;
   iibs_pkg::entry_type              cur_ff;
   logic [iibs_pkg::TOTAL_W-1:0]     acc_ff;
   logic [iibs_pkg::TOTAL_W-1:0]     rd_data_ff;
   logic                             rsp_valid_ff;
   logic [iibs_pkg::GRAY_W-1:0]      rsp_gray_ff;
   logic [iibs_pkg::TOTAL_W-1:0]     rsp_running_total_ff;
   logic [iibs_pkg::TOTAL_W-1:0]     rsp_box_sum_ff;
   logic                             rsp_outside_ff;

   logic [iibs_pkg::TOTAL_W-1:0]     area_store [1 << iibs_pkg::ADDR_W];
   logic [iibs_pkg::ADDR_W-1:0]      mem_addr;
   logic                             mem_we;
   logic [iibs_pkg::TOTAL_W-1:0]     pix_total_in;
   logic [iibs_pkg::TOTAL_W-1:0]     box_sum_in;

   assign pop_en = (state_ff == S_IDLE) && !queue_empty;
   assign mem_we = state_ff == S_PIX_WR;

   // Reads serve the following state; S_PIX_WR presents the write address.
   always_comb begin
      unique case (state_ff)
         S_IDLE: begin
            if (head.op == iibs_pkg::OP_PIXEL) begin
               mem_addr = {head.y0, head.x1};
            end else begin
               mem_addr = {head.y1, head.x1};
            end
         end
         S_PIX_WR: mem_addr = {cur_ff.y1, cur_ff.x1};
         S_READ_B: mem_addr = {cur_ff.y0, cur_ff.x0};
         S_READ_C: mem_addr = {cur_ff.y1, cur_ff.x0};
         S_READ_D: mem_addr = {cur_ff.y0, cur_ff.x1};
         S_Q_DONE: mem_addr = '0;
         default:  mem_addr = '0;
      endcase
   end

   assign pix_total_in = iibs_pkg::TOTAL_W'(cur_ff.row_sum) +
                         (cur_ff.top_ok ? rd_data_ff : '0);
   assign box_sum_in   = cur_ff.outside ? '0 :
                         acc_ff - (cur_ff.top_ok ? rd_data_ff : '0);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         area_store[mem_addr] <= pix_total_in;
      end
      rd_data_ff <= area_store[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (pop_en) begin
                  cur_ff <= head;
                  if (head.op == iibs_pkg::OP_PIXEL) begin
                     state_ff <= S_PIX_WR;
                  end else if (head.outside) begin
                     state_ff <= S_Q_DONE;
                  end else begin
                     state_ff <= S_READ_B;
                  end
               end
            end
            S_PIX_WR: begin
               rsp_valid_ff         <= 1'b1;
               rsp_gray_ff          <= cur_ff.gray;
               rsp_running_total_ff <= pix_total_in;
               rsp_box_sum_ff       <= '0;
               rsp_outside_ff       <= 1'b0;
               state_ff             <= S_IDLE;
            end
            S_READ_B: begin
               acc_ff   <= rd_data_ff;
               state_ff <= S_READ_C;
            end
            S_READ_C: begin
               acc_ff   <= acc_ff +
                           ((cur_ff.left_ok && cur_ff.top_ok) ? rd_data_ff : '0);
               state_ff <= S_READ_D;
            end
            S_READ_D: begin
               acc_ff   <= acc_ff - (cur_ff.left_ok ? rd_data_ff : '0);
               state_ff <= S_Q_DONE;
            end
            S_Q_DONE: begin
               rsp_valid_ff         <= 1'b1;
               rsp_gray_ff          <= '0;
               rsp_running_total_ff <= '0;
               rsp_box_sum_ff       <= box_sum_in;
               rsp_outside_ff       <= cur_ff.outside;
               state_ff             <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_gray          = rsp_gray_ff;
   assign rsp_running_total = rsp_running_total_ff;
   assign rsp_box_sum       = rsp_box_sum_ff;
   assign rsp_outside       = rsp_outside_ff;

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == S_PIX_WR || $past(state_ff) == S_Q_DONE))
      else $error("result word raised outside a finishing state");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("two result words in consecutive cycles");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_outside_ff) |-> (rsp_box_sum_ff == '0 && rsp_gray_ff == '0))
      else $error("flagged query carries a nonzero result");

endmodule
`default_nettype wire

FILE: hw/rtl/integral_image_box_sum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integral image box sum
// Builds a summed-area table of a gray frame and answers box sum queries.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. The front end holds
// one word and feeds a two-word queue; busy rises only while the held word
// cannot enter a full queue. The back end owns a single-port frame store of
// 512 x 512 entries and works on one word at a time: a pixel makes one read
// of the entry above and one write, a query makes four corner reads through
// the one port and then gives the result, and a box flagged as outside gives
// its result with no corner reads. The sustained rate is therefore set by the
// store port. Each result is shown for exactly one cycle with rsp_valid and the
// receiver cannot stall it. The store is not cleared after reset; queries
// must only touch entries already written. Write image_width or
// image_height only while no word is in flight; each write restarts the frame.
// ----------------------------------------------------------------------------
module integral_image_box_sum (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic                                  req_op,
   input  wire logic [iibs_pkg::CHAN_W-1:0]           req_chan_a,
   input  wire logic [iibs_pkg::CHAN_W-1:0]           req_chan_b,
   input  wire logic [iibs_pkg::CHAN_W-1:0]           req_chan_c,
   input  wire logic [iibs_pkg::COORD_W-1:0]          req_query_x,
   input  wire logic [iibs_pkg::COORD_W-1:0]          req_query_y,
   input  wire logic [iibs_pkg::DIM_W-1:0]            req_box_width,
   input  wire logic [iibs_pkg::DIM_W-1:0]            req_box_height,
   input  wire logic                                  csr_write_en,
   input  wire logic [iibs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [iibs_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic                                       rsp_valid,
   output logic [iibs_pkg::GRAY_W-1:0]                rsp_gray,
   output logic [iibs_pkg::TOTAL_W-1:0]               rsp_running_total,
   output logic [iibs_pkg::TOTAL_W-1:0]               rsp_box_sum,
   output logic                                       rsp_outside
);

   iibs_pkg::csr_write_type  csr;
   iibs_pkg::entry_type      push_entry;
   iibs_pkg::entry_type      head;
   logic                     push_en;
   logic                     pop_en;
   logic                     queue_full;
   logic                     queue_empty;

   assign csr.en    = csr_write_en;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   iibs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .op         (req_op),
      .chan_a     (req_chan_a),
      .chan_b     (req_chan_b),
      .chan_c     (req_chan_c),
      .query_x    (req_query_x),
      .query_y    (req_query_y),
      .box_width  (req_box_width),
      .box_height (req_box_height),
      .csr        (csr),
      .push_en    (push_en),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   iibs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_en    (push_en),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_en     (pop_en),
      .head       (head),
      .empty      (queue_empty)
   );

   iibs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (queue_empty),
      .head              (head),
      .pop_en            (pop_en),
      .rsp_valid         (rsp_valid),
      .rsp_gray          (rsp_gray),
      .rsp_running_total (rsp_running_total),
      .rsp_box_sum       (rsp_box_sum),
      .rsp_outside       (rsp_outside)
   );

endmodule
`default_nettype wire

FILE: tb/integral_image_box_sum_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integral image box sum testbench
// Streams pixel and box query words into the block and checks every result
// against a predictor. The predictor keeps its own summed-area table and frame
// position. Directed words cover the gray weights, the box corners, frame
// wrap and register limits. Random frames follow, with fitted and noisy
// queries and random sender gaps.
// ----------------------------------------------------------------------------
module integral_image_box_sum_tb;
   import iibs_pkg::*;

   localparam int CYCLE_LIMIT  = 400_000;
   localparam int RANDOM_WORDS = 1750;
   localparam int SETTLE_CYCLES = 8;
   localparam int TABLE_DEPTH  = MAX_WIDTH * MAX_HEIGHT;

   typedef struct packed {
      op_type               op;
      logic [CHAN_W-1:0]    chan_a;
      logic [CHAN_W-1:0]    chan_b;
      logic [CHAN_W-1:0]    chan_c;
      logic [COORD_W-1:0]   query_x;
      logic [COORD_W-1:0]   query_y;
      logic [DIM_W-1:0]     box_width;
      logic [DIM_W-1:0]     box_height;
   } req_word_type;

   typedef struct packed {
      logic [GRAY_W-1:0]    gray;
      logic [TOTAL_W-1:0]   running_total;
      logic [TOTAL_W-1:0]   box_sum;
      logic                 outside;
   } rsp_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_op = 1'b0;
   logic [CHAN_W-1:0]        req_chan_a = '0;
   logic [CHAN_W-1:0]        req_chan_b = '0;
   logic [CHAN_W-1:0]        req_chan_c = '0;
   logic [COORD_W-1:0]       req_query_x = '0;
   logic [COORD_W-1:0]       req_query_y = '0;
   logic [DIM_W-1:0]         req_box_width = '0;
   logic [DIM_W-1:0]         req_box_height = '0;
   logic                     csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;
   logic                     rsp_valid;
   logic [GRAY_W-1:0]        rsp_gray;
   logic [TOTAL_W-1:0]       rsp_running_total;
   logic [TOTAL_W-1:0]       rsp_box_sum;
   logic                     rsp_outside;

   // Predictor state: the summed-area table and the frame position.
   logic [TOTAL_W-1:0]       area_table [TABLE_DEPTH];
   bit                       area_written [TABLE_DEPTH];
   logic [DIM_W-1:0]         width_reg = DIM_W'(512);
   logic [DIM_W-1:0]         height_reg = DIM_W'(512);
   logic [RSUM_W-1:0]        row_acc = '0;
   int                       next_col = 0;
   int                       next_row = 0;

   rsp_word_type             pending_results [$];
   int                       error_count = 0;
   int                       words_sent = 0;
   int                       cycle_count = 0;
   bit                       sender_idles = 1'b0;

   integral_image_box_sum i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_chan_a        (req_chan_a),
      .req_chan_b        (req_chan_b),
      .req_chan_c        (req_chan_c),
      .req_query_x       (req_query_x),
      .req_query_y       (req_query_y),
      .req_box_width     (req_box_width),
      .req_box_height    (req_box_height),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_gray          (rsp_gray),
      .rsp_running_total (rsp_running_total),
      .rsp_box_sum       (rsp_box_sum),
      .rsp_outside       (rsp_outside)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("integral_image_box_sum regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic int eff_size(logic [DIM_W-1:0] value, int limit);
      if (value == '0) return 1;
      if (int'(value) > limit) return limit;
      return int'(value);
   endfunction

   function automatic int frame_cols();
      return eff_size(width_reg, MAX_WIDTH);
   endfunction

   function automatic int frame_rows();
      return eff_size(height_reg, MAX_HEIGHT);
   endfunction

   function automatic logic [GRAY_W-1:0] gray_of(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                                 logic [CHAN_W-1:0] c);
      int weighted;
      weighted = int'(GRAY_WEIGHT_A) * a + int'(GRAY_WEIGHT_B) * b
               + int'(GRAY_WEIGHT_C) * c + int'(GRAY_ROUND);
      return GRAY_W'(weighted >> 8);
   endfunction

   function automatic bit box_outside(int x, int y, int bw, int bh);
      return bw == 0 || bh == 0 || x + bw > frame_cols() || y + bh > frame_rows();
   endfunction

   // True when the box reads no table entry that was never written.
   function automatic bit corners_written(int x, int y, int bw, int bh);
      int x1;
      int y1;
      bit ok;
      if (box_outside(x, y, bw, bh)) return 1'b1;
      x1 = x + bw - 1;
      y1 = y + bh - 1;
      ok = area_written[y1 * MAX_WIDTH + x1];
      if (x > 0 && y > 0) ok &= area_written[(y - 1) * MAX_WIDTH + x - 1];
      if (x > 0) ok &= area_written[y1 * MAX_WIDTH + x - 1];
      if (y > 0) ok &= area_written[(y - 1) * MAX_WIDTH + x1];
      return ok;
   endfunction

   function automatic void apply_register(logic [CSR_INDEX_W-1:0] index,
                                          logic [DIM_W-1:0] value);
      if (index == CSR_IMAGE_WIDTH) width_reg = value;
      else height_reg = value;
      row_acc = '0;
      next_col = 0;
      next_row = 0;
   endfunction

   function automatic void predict_word(req_word_type w);
      rsp_word_type r;
      int cols;
      int rows;
      int col;
      int row;
      int x;
      int y;
      int x1;
      int y1;
      logic [TOTAL_W-1:0] sum;
      cols = frame_cols();
      rows = frame_rows();
      r = '0;
      if (w.op == OP_PIXEL) begin
         r.gray = gray_of(w.chan_a, w.chan_b, w.chan_c);
         col = next_col;
         row = next_row;
         if (col >= cols || row >= rows) begin
            col = 0;
            row = 0;
            row_acc = '0;
         end
         if (col == 0) row_acc = '0;
         row_acc = row_acc + RSUM_W'(r.gray);
         r.running_total = TOTAL_W'(row_acc);
         if (row > 0) r.running_total += area_table[(row - 1) * MAX_WIDTH + col];
         area_table[row * MAX_WIDTH + col] = r.running_total;
         area_written[row * MAX_WIDTH + col] = 1'b1;
         col++;
         if (col >= cols) begin
            col = 0;
            row++;
            if (row >= rows) row = 0;
         end
         next_col = col;
         next_row = row;
      end else if (box_outside(w.query_x, w.query_y, w.box_width, w.box_height)) begin
         r.outside = 1'b1;
      end else begin
         x = w.query_x;
         y = w.query_y;
         x1 = x + w.box_width - 1;
         y1 = y + w.box_height - 1;
         // Four-corner sum, wrapping at the table width like the store does.
         sum = area_table[y1 * MAX_WIDTH + x1];
         if (x > 0 && y > 0) sum += area_table[(y - 1) * MAX_WIDTH + x - 1];
         if (x > 0) sum -= area_table[y1 * MAX_WIDTH + x - 1];
         if (y > 0) sum -= area_table[(y - 1) * MAX_WIDTH + x1];
         r.box_sum = sum;
      end
      pending_results = {pending_results, r};
   endfunction

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------
   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      rsp_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result word with nothing outstanding, expected none, actual %0d %0d %0d %0d",
                     $time, rsp_gray, rsp_running_total, rsp_box_sum, rsp_outside);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("gray", want.gray, rsp_gray);
            check_field("running_total", want.running_total, rsp_running_total);
            check_field("box_sum", want.box_sum, rsp_box_sum);
            check_field("outside", want.outside, rsp_outside);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers; every task returns right after a rising edge.
   // ------------------------------------------------------------------------
   function automatic req_word_type random_word(op_type op);
      req_word_type w;
      w.op = op;
      w.chan_a = CHAN_W'($urandom_range(0, 255));
      w.chan_b = CHAN_W'($urandom_range(0, 255));
      w.chan_c = CHAN_W'($urandom_range(0, 255));
      w.query_x = COORD_W'($urandom_range(0, 511));
      w.query_y = COORD_W'($urandom_range(0, 511));
      w.box_width = DIM_W'($urandom_range(0, 1023));
      w.box_height = DIM_W'($urandom_range(0, 1023));
      return w;
   endfunction

   function automatic req_word_type pixel_word(int a, int b, int c);
      req_word_type w;
      w = random_word(OP_PIXEL);
      w.chan_a = CHAN_W'(a);
      w.chan_b = CHAN_W'(b);
      w.chan_c = CHAN_W'(c);
      return w;
   endfunction

   function automatic req_word_type box_word(int x, int y, int bw, int bh);
      req_word_type w;
      w = random_word(OP_QUERY);
      w.query_x = COORD_W'(x);
      w.query_y = COORD_W'(y);
      w.box_width = DIM_W'(bw);
      w.box_height = DIM_W'(bh);
      return w;
   endfunction

   task automatic send_word(req_word_type w);
      int gap;
      req_op <= w.op;
      req_chan_a <= w.chan_a;
      req_chan_b <= w.chan_b;
      req_chan_c <= w.chan_c;
      req_query_x <= w.query_x;
      req_query_y <= w.query_y;
      req_box_width <= w.box_width;
      req_box_height <= w.box_height;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predict_word(w);
      words_sent++;
      gap = sender_idles ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The trailing edge keeps back-to-back writes from lowering and raising
   // the enable in one time step.
   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [DIM_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      apply_register(index, value);
      @(posedge clock);
   endtask

   task automatic send_query_fitted();
      req_word_type w;
      int cols;
      int rows;
      int x;
      int y;
      int bw;
      int bh;
      cols = frame_cols();
      rows = frame_rows();
      w = random_word(OP_QUERY);
      w.box_width = '0;
      repeat (16) begin
         x = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, cols - 1);
         y = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, rows - 1);
         bw = ($urandom_range(0, 7) == 0) ? cols - x : $urandom_range(1, cols - x);
         bh = ($urandom_range(0, 7) == 0) ? rows - y : $urandom_range(1, rows - y);
         if (corners_written(x, y, bw, bh)) begin
            w = box_word(x, y, bw, bh);
            break;
         end
      end
      send_word(w);
   endtask

   task automatic send_query_noise();
      req_word_type w;
      w = random_word(OP_QUERY);
      if ($urandom_range(0, 1) == 1) begin
         w.box_width = DIM_W'($urandom_range(0, frame_cols() + 1));
         w.box_height = DIM_W'($urandom_range(0, frame_rows() + 1));
      end
      if (!corners_written(w.query_x, w.query_y, w.box_width, w.box_height))
         w.box_height = '0;
      send_word(w);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_gray_weights();
      wait_drained();
      write_reg(CSR_IMAGE_WIDTH, DIM_W'(3));
      write_reg(CSR_IMAGE_HEIGHT, DIM_W'(2));
      send_word(pixel_word(0, 0, 0));
      send_word(pixel_word(255, 255, 255));
      send_word(pixel_word(255, 0, 0));
      send_word(pixel_word(0, 255, 0));
      send_word(pixel_word(0, 0, 255));
      send_word(pixel_word(1, 128, 254));
   endtask

   task automatic test_box_corners();
      send_word(box_word(0, 0, 3, 2));
      send_word(box_word(2, 1, 1, 1));
      send_word(box_word(1, 1, 2, 1));
      send_word(box_word(1, 0, 2, 2));
      send_word(box_word(0, 0, 0, 2));
      send_word(box_word(0, 0, 3, 0));
      send_word(box_word(1, 0, 3, 1));
      send_word(box_word(0, 1, 1, 2));
      send_word(box_word(511, 511, 512, 512));
      send_word(box_word(0, 0, 1023, 1023));
   endtask

   // The pixel after the last one of a frame lands at the top-left again.
   task automatic test_frame_wrap();
      sender_idles = 1'b1;
      send_word(pixel_word(10, 20, 30));
      wait_drained();
      send_word(box_word(0, 0, 3, 2));
   endtask

   task automatic test_register_limits();
      wait_drained();
      write_reg(CSR_IMAGE_WIDTH, DIM_W'(0));
      write_reg(CSR_IMAGE_HEIGHT, DIM_W'(0));
      send_word(pixel_word(200, 100, 50));
      send_word(pixel_word(7, 8, 9));
      send_word(box_word(0, 0, 1, 1));
      send_word(box_word(0, 0, 2, 1));
      wait_drained();
      write_reg(CSR_IMAGE_WIDTH, DIM_W'(1023));
      write_reg(CSR_IMAGE_HEIGHT, DIM_W'(1023));
      send_word(pixel_word(255, 255, 255));
      send_word(box_word(0, 0, 1, 1));
      send_word(box_word(0, 0, 513, 1));
   endtask

   // The first phase builds a wide row, the second a tall column, so that
   // queries reach the high coordinates; mostly small frames follow.
   task automatic test_random_frames();
      int first;
      int phase;
      int fill;
      int pick;
      logic [DIM_W-1:0] wv;
      logic [DIM_W-1:0] hv;
      first = words_sent;
      phase = 0;
      while (words_sent - first < RANDOM_WORDS) begin
         case (phase)
            0: begin
               wv = DIM_W'($urandom_range(257, 1023));
               hv = DIM_W'($urandom_range(0, 1));
            end
            1: begin
               wv = DIM_W'($urandom_range(0, 1));
               hv = DIM_W'($urandom_range(257, 1023));
            end
            default: begin
               wv = DIM_W'($urandom_range(1, 24));
               hv = DIM_W'($urandom_range(1, 24));
               pick = $urandom_range(0, 9);
               if (pick == 0) wv = '0;
               if (pick == 1) hv = '0;
               if (pick == 2) wv = DIM_W'($urandom_range(513, 1023));
               if (pick == 3) hv = DIM_W'(512);
            end
         endcase
         wait_drained();
         if (phase < 2 || $urandom_range(0, 3) != 0) begin
            write_reg(CSR_IMAGE_WIDTH, wv);
            write_reg(CSR_IMAGE_HEIGHT, hv);
         end else if ($urandom_range(0, 1) == 1) begin
            write_reg(CSR_IMAGE_WIDTH, wv);
         end else begin
            write_reg(CSR_IMAGE_HEIGHT, hv);
         end
         sender_idles = $urandom_range(0, 2) != 0;
         fill = frame_cols() * frame_rows();
         if (fill > 600) fill = $urandom_range(300, 600);
         else fill += $urandom_range(0, fill / 4);
         repeat (fill) send_word(random_word(OP_PIXEL));
         repeat ($urandom_range(20, 80)) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) send_query_fitted();
            else if (pick < 8) send_word(random_word(OP_PIXEL));
            else send_query_noise();
         end
         phase++;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_gray_weights();
      test_box_corners();
      test_frame_wrap();
      test_register_limits();
      test_random_frames();
      wait_drained();
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("integral_image_box_sum regression: pass");
      end else begin
         $display("integral_image_box_sum regression: fail");
      end
      $finish;
   end

endmodule
